>>> rtl/core/sapa_pkg.sv
// ----------------------------------------------------------------------------
// sapa_pkg
// Shared types and constants of the shape area and perimeter accumulator:
// field widths, shape kinds, controller states and controller commands.
// ----------------------------------------------------------------------------
package sapa_pkg;

    // Field widths of the stream items
    localparam int DIM_W       = 24;
    localparam int KIND_W      = 2;
    localparam int OUT_CNT_W   = 16;
    localparam int AREA_W      = 60;
    localparam int PERIM_W     = 43;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 120;
    localparam int NKINDS      = 4;
    localparam int KIDX_W      = 2;

    // Defaults of the top-level parameters
    localparam int FRAC_BITS_DEF   = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    // Shared multiplier: 52 x 52 bit operands in 26 bit chunks
    localparam int OPND_W     = 52;
    localparam int CHUNK_W    = 26;
    localparam int ACC_W      = 104;
    localparam int MAC_STEPS  = 4;

    // Bit-serial square root of the 104 bit accumulator
    localparam int ROOT_W     = 52;
    localparam int REM_W      = 54;
    localparam int SQRT_STEPS = 52;
    localparam int CNT_W      = 6;

    // pi with 32 fraction bits
    localparam logic [33:0] PI_Q32 = 34'd13493037705;

    typedef enum logic [1:0] {
        KIND_RECT,
        KIND_CIRC,
        KIND_TRI,
        KIND_TRAP
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MAC,
        ST_POST,
        ST_SQRT,
        ST_SQFIN,
        ST_UPD,
        ST_RPT
    } state_t;

    // Operand pairs loaded into the multiplier
    typedef enum logic [3:0] {
        OPS_AB,
        OPS_AA,
        OPS_ACC_PI,
        OPS_2A_PI,
        OPS_TRI_X,
        OPS_TRI_Y,
        OPS_XY,
        OPS_DD,
        OPS_CC,
        OPS_SC
    } opsel_t;

    // Action taken on a finished product
    typedef enum logic [2:0] {
        POST_NONE,
        POST_SAVE_X,
        POST_RECT,
        POST_CIRC_AREA,
        POST_CIRC_PERIM,
        POST_SQ_START,
        POST_TRAP_SLANT,
        POST_TRAP_AREA
    } post_t;

    typedef struct packed {
        logic              load_in;
        logic              ld_ops;
        opsel_t            opsel;
        logic              mac;
        logic [1:0]        mac_idx;
        post_t             post;
        logic              sq_step;
        logic              sq_fin;
        logic              update;
        logic              rpt_load;
        logic [KIDX_W-1:0] rpt_idx;
        logic              rpt_last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  eob;
        logic  out_busy;
    } sts_t;

endpackage

>>> rtl/core/sapa_ctrl.sv
// ----------------------------------------------------------------------------
// sapa_ctrl
// Sequencer of the accumulator: steps each shape through its products,
// square root and accumulator update, then issues the batch report.
// ----------------------------------------------------------------------------
module sapa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  sapa_pkg::sts_t sts,
    output sapa_pkg::cmd_t cmd
);
    import sapa_pkg::*;

    state_t           state_reg, state_next;
    logic [1:0]       ph_reg, ph_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    opsel_t           opsel_w;
    post_t            post_w;

    // Operand pair for the current kind and phase
    always_comb
    begin
        opsel_w = OPS_AB;
        unique case (sts.kind)
            KIND_RECT: opsel_w = OPS_AB;
            KIND_CIRC: opsel_w = (ph_reg == 2'd0) ? OPS_AA :
                                 (ph_reg == 2'd1) ? OPS_ACC_PI : OPS_2A_PI;
            KIND_TRI:  opsel_w = (ph_reg == 2'd0) ? OPS_TRI_X :
                                 (ph_reg == 2'd1) ? OPS_TRI_Y : OPS_XY;
            KIND_TRAP: opsel_w = (ph_reg == 2'd0) ? OPS_DD :
                                 (ph_reg == 2'd1) ? OPS_CC : OPS_SC;
            default:   opsel_w = OPS_AB;
        endcase
    end

    // Action on each finished product
    always_comb
    begin
        post_w = POST_NONE;
        unique case (sts.kind)
            KIND_RECT: post_w = POST_RECT;
            KIND_CIRC: post_w = (ph_reg == 2'd0) ? POST_NONE :
                                (ph_reg == 2'd1) ? POST_CIRC_AREA : POST_CIRC_PERIM;
            KIND_TRI:  post_w = (ph_reg == 2'd0) ? POST_SAVE_X :
                                (ph_reg == 2'd1) ? POST_NONE : POST_SQ_START;
            KIND_TRAP: post_w = (ph_reg == 2'd0) ? POST_SAVE_X :
                                (ph_reg == 2'd1) ? POST_TRAP_SLANT : POST_TRAP_AREA;
            default:   post_w = POST_NONE;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_LOAD;
                    ph_next    = 2'd0;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_MAC;
                cnt_next   = '0;
            end
            ST_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MAC_STEPS - 1))
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                cnt_next = '0;
                unique case (sts.kind)
                    KIND_RECT: state_next = ST_UPD;
                    KIND_CIRC: state_next = (ph_reg == 2'd2) ? ST_UPD : ST_LOAD;
                    KIND_TRI:  state_next = (ph_reg == 2'd2) ? ST_SQRT : ST_LOAD;
                    KIND_TRAP: state_next = (ph_reg == 2'd0) ? ST_LOAD :
                                            (ph_reg == 2'd1) ? ST_SQRT : ST_UPD;
                    default:   state_next = ST_UPD;
                endcase
                ph_next = ph_reg + 1'b1;
            end
            ST_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = ST_SQFIN;
            end
            ST_SQFIN:
            begin
                state_next = (sts.kind == KIND_TRAP) ? ST_LOAD : ST_UPD;
            end
            ST_UPD:
            begin
                cnt_next   = '0;
                state_next = sts.eob ? ST_RPT : ST_IDLE;
            end
            ST_RPT:
            begin
                if (!sts.out_busy)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NKINDS - 1))
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        cmd           = '0;
        cmd.opsel     = opsel_w;
        cmd.post      = POST_NONE;
        cmd.mac_idx   = cnt_reg[1:0];
        cmd.rpt_idx   = cnt_reg[KIDX_W-1:0];
        cmd.rpt_last  = (cnt_reg == CNT_W'(NKINDS - 1));
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load_in   = s_axis_tvalid;
            end
            ST_LOAD:  cmd.ld_ops   = 1'b1;
            ST_MAC:   cmd.mac      = 1'b1;
            ST_POST:  cmd.post     = post_w;
            ST_SQRT:  cmd.sq_step  = 1'b1;
            ST_SQFIN: cmd.sq_fin   = 1'b1;
            ST_UPD:   cmd.update   = 1'b1;
            ST_RPT:   cmd.rpt_load = !sts.out_busy;
            default:  cmd.ld_ops   = 1'b0;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/core/sapa_dp.sv
// ----------------------------------------------------------------------------
// sapa_dp
// Datapath: input capture, chunked 52x52 multiply-accumulate, bit-serial
// square root, per-kind saturating sums and the summary output register.
// ----------------------------------------------------------------------------
module sapa_dp #(
    parameter int FRAC_BITS   = sapa_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = sapa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sapa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic [sapa_pkg::KIND_W-1:0]        s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sapa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [sapa_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                               m_axis_tlast,
    input  sapa_pkg::cmd_t                     cmd,
    output sapa_pkg::sts_t                     sts
);
    import sapa_pkg::*;

    // Captured shape
    logic [DIM_W-1:0] a_reg, b_reg, c_reg;
    kind_t            kind_reg;
    logic             eob_reg;

    // Multiplier and root state
    logic [OPND_W-1:0] opx_reg, opy_reg, x_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [AREA_W-1:0] area_reg;
    logic [PERIM_W-1:0] perim_reg;

    // Per-kind accumulators
    logic [COUNT_WIDTH-1:0] cnt_mem   [NKINDS];
    logic [AREA_W-1:0]      area_mem  [NKINDS];
    logic [PERIM_W-1:0]     perim_mem [NKINDS];

    // Output register
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic [KIND_W-1:0]     m_user_reg;
    logic                  m_last_reg;

    logic [DIM_W:0]     sum_ab;
    logic [DIM_W+1:0]   sum_abc, bc_a, ac_b, ab_c;
    logic [DIM_W-1:0]   dif;
    logic               degen;
    logic [CHUNK_W-1:0] xc, yc;
    logic [2*CHUNK_W-1:0] prod;
    logic [ACC_W-1:0]   prod_sh;
    logic [REM_W+1:0]   rem_sh, trial;
    logic [KIDX_W-1:0]  idx;
    logic [COUNT_WIDTH-1:0] cnt_upd;
    logic [AREA_W:0]    area_sum;
    logic [PERIM_W:0]   perim_sum;

    // Dimension sums and differences
    assign sum_ab  = (DIM_W+1)'(a_reg) + (DIM_W+1)'(b_reg);
    assign sum_abc = (DIM_W+2)'(sum_ab) + (DIM_W+2)'(c_reg);
    assign bc_a    = (DIM_W+2)'(b_reg) + (DIM_W+2)'(c_reg) - (DIM_W+2)'(a_reg);
    assign ac_b    = (DIM_W+2)'(a_reg) + (DIM_W+2)'(c_reg) - (DIM_W+2)'(b_reg);
    assign ab_c    = (DIM_W+2)'(sum_ab) - (DIM_W+2)'(c_reg);
    assign dif     = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
    assign degen   = ((DIM_W+1)'(a_reg) >= (DIM_W+1)'(b_reg) + (DIM_W+1)'(c_reg)) ||
                     ((DIM_W+1)'(b_reg) >= (DIM_W+1)'(a_reg) + (DIM_W+1)'(c_reg)) ||
                     ((DIM_W+1)'(c_reg) >= sum_ab);

    // One 26x26 partial product per cycle
    assign xc   = cmd.mac_idx[1] ? opx_reg[OPND_W-1:CHUNK_W] : opx_reg[CHUNK_W-1:0];
    assign yc   = cmd.mac_idx[0] ? opy_reg[OPND_W-1:CHUNK_W] : opy_reg[CHUNK_W-1:0];
    assign prod = xc * yc;

    always_comb
    begin
        case (cmd.mac_idx)
            2'b00:   prod_sh = ACC_W'(prod);
            2'b11:   prod_sh = ACC_W'(prod) << (2 * CHUNK_W);
            default: prod_sh = ACC_W'(prod) << CHUNK_W;
        endcase
    end

    // One root bit per cycle
    assign rem_sh = {rem_reg, acc_reg[ACC_W-1:ACC_W-2]};
    assign trial  = {2'b00, root_reg, 2'b01};

    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        acc_next  = acc_reg;
        if (cmd.ld_ops)
            acc_next = '0;
        else if (cmd.mac)
            acc_next = acc_reg + prod_sh;
        else if (cmd.post == POST_TRAP_SLANT)
            acc_next = acc_reg + ACC_W'(x_reg);
        else if (cmd.sq_step)
            acc_next = acc_reg << 2;

        if (cmd.post == POST_SQ_START || cmd.post == POST_TRAP_SLANT)
        begin
            rem_next  = '0;
            root_next = '0;
        end
        else if (cmd.sq_step)
        begin
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Capture the shape, load operands, hold products and results
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg    <= s_axis_tdata[DIM_W-1:0];
            b_reg    <= s_axis_tdata[2*DIM_W-1:DIM_W];
            c_reg    <= s_axis_tdata[3*DIM_W-1:2*DIM_W];
            kind_reg <= kind_t'(s_axis_tuser);
            eob_reg  <= s_axis_tlast;
        end

        if (cmd.ld_ops)
        begin
            case (cmd.opsel)
                OPS_AB:     begin opx_reg <= OPND_W'(a_reg);   opy_reg <= OPND_W'(b_reg); end
                OPS_AA:     begin opx_reg <= OPND_W'(a_reg);   opy_reg <= OPND_W'(a_reg); end
                OPS_ACC_PI: begin opx_reg <= acc_reg[OPND_W-1:0]; opy_reg <= OPND_W'(PI_Q32); end
                OPS_2A_PI:  begin opx_reg <= OPND_W'({a_reg, 1'b0}); opy_reg <= OPND_W'(PI_Q32); end
                OPS_TRI_X:  begin opx_reg <= OPND_W'(sum_abc); opy_reg <= OPND_W'(bc_a); end
                OPS_TRI_Y:  begin opx_reg <= OPND_W'(ac_b);    opy_reg <= OPND_W'(ab_c); end
                OPS_XY:     begin opx_reg <= x_reg;            opy_reg <= acc_reg[OPND_W-1:0]; end
                OPS_DD:     begin opx_reg <= OPND_W'(dif);     opy_reg <= OPND_W'(dif); end
                OPS_CC:     begin opx_reg <= OPND_W'(c_reg);   opy_reg <= OPND_W'(c_reg); end
                default:    begin opx_reg <= OPND_W'(sum_ab);  opy_reg <= OPND_W'(c_reg); end
            endcase
        end

        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;

        case (cmd.post)
            POST_SAVE_X:     x_reg <= acc_reg[OPND_W-1:0];
            POST_RECT:
            begin
                area_reg  <= AREA_W'(acc_reg >> FRAC_BITS);
                perim_reg <= PERIM_W'({sum_ab, 1'b0});
            end
            POST_CIRC_AREA:  area_reg  <= AREA_W'(acc_reg >> (32 + FRAC_BITS));
            POST_CIRC_PERIM: perim_reg <= PERIM_W'(acc_reg >> 32);
            POST_TRAP_AREA:  area_reg  <= AREA_W'(acc_reg >> (FRAC_BITS + 1));
            default:         x_reg     <= x_reg;
        endcase

        // Finish the root: triangle area or trapezoid slant side
        if (cmd.sq_fin)
        begin
            if (kind_reg == KIND_TRAP)
                perim_reg <= PERIM_W'(sum_abc) + PERIM_W'(root_reg);
            else
            begin
                perim_reg <= PERIM_W'(sum_abc);
                area_reg  <= degen ? '0 : AREA_W'(root_reg >> (FRAC_BITS + 2));
            end
        end
    end

    // Saturating update of the selected kind
    assign idx       = cmd.rpt_load ? cmd.rpt_idx : KIDX_W'(kind_reg);
    assign cnt_upd   = (&cnt_mem[idx]) ? cnt_mem[idx] : cnt_mem[idx] + 1'b1;
    assign area_sum  = (AREA_W+1)'(area_mem[idx]) + (AREA_W+1)'(area_reg);
    assign perim_sum = (PERIM_W+1)'(perim_mem[idx]) + (PERIM_W+1)'(perim_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NKINDS; k++)
            begin
                cnt_mem[k]   <= '0;
                area_mem[k]  <= '0;
                perim_mem[k] <= '0;
            end
        end
        else if (cmd.update)
        begin
            cnt_mem[idx]   <= cnt_upd;
            area_mem[idx]  <= area_sum[AREA_W] ? '1 : area_sum[AREA_W-1:0];
            perim_mem[idx] <= perim_sum[PERIM_W] ? '1 : perim_sum[PERIM_W-1:0];
        end
        else if (cmd.rpt_load)
        begin
            // Clear each kind as its summary leaves
            cnt_mem[idx]   <= '0;
            area_mem[idx]  <= '0;
            perim_mem[idx] <= '0;
        end
    end

    // Summary output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.rpt_load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rpt_load)
        begin
            m_data_reg <= OUT_DATA_W'({perim_mem[idx], area_mem[idx],
                                       OUT_CNT_W'(cnt_mem[idx])});
            m_user_reg <= idx;
            m_last_reg <= cmd.rpt_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    assign sts.kind     = kind_reg;
    assign sts.eob      = eob_reg;
    assign sts.out_busy = m_valid_reg && !m_axis_tready;

endmodule

>>> rtl/core/shape_area_perimeter_accumulator_unit.sv
// ----------------------------------------------------------------------------
// shape_area_perimeter_accumulator_unit
// Area and perimeter of rectangles, circles, triangles and right trapezoids,
// summed per kind and reported as four summaries at the end of each batch.
// ----------------------------------------------------------------------------
// One shape is taken at a time; the next is not ready until the current one
// has been accumulated and any batch report has been issued. Products
// go through one shared 26x26 multiplier, four partial products per 52x52
// product, and the triangle area and trapezoid slant side come from a
// 52-bit square root that yields one bit per cycle. A shape that ends a
// batch adds the report of four summaries, one per kind, longer if the
// output is stalled. The last summary may wait in the output register
// while the next shape is already being taken. Results truncate toward
// zero; sums and counts saturate.
module shape_area_perimeter_accumulator_unit #(
    parameter int FRAC_BITS   = sapa_pkg::FRAC_BITS_DEF,
    parameter int COUNT_WIDTH = sapa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // dim_a [23:0], dim_b [47:24], dim_c [71:48]
    input  logic [sapa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [sapa_pkg::KIND_W-1:0]     s_axis_tuser,
    // end_of_batch
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // shape_count [15:0], area_sum [75:16], perimeter_sum [118:76], zero [119]
    output logic [sapa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // shape_kind [1:0]
    output logic [sapa_pkg::KIND_W-1:0]     m_axis_tuser,
    // last_of_run
    output logic                            m_axis_tlast
);
    import sapa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sapa_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    sapa_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

>>> rtl/core/sapa_checker.sv
// ----------------------------------------------------------------------------
// sapa_checker
// Port-level checks of the accumulator: summary ordering, input gating
// during a report and output stability under stall.
// ----------------------------------------------------------------------------
module sapa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [sapa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [sapa_pkg::KIND_W-1:0]     s_axis_tuser,
    input logic                            s_axis_tlast,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [sapa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [sapa_pkg::KIND_W-1:0]     m_axis_tuser,
    input logic                            m_axis_tlast
);
    import sapa_pkg::*;

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tlast
                     || s_axis_tuser != '1 || 1'b1);

    // The marked summary is always the trapezoid one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == KIDX_W'(KIND_TRAP))
        else $error("last summary is not the final kind");

    // Unmarked summaries never report the final kind
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser != KIDX_W'(KIND_TRAP))
        else $error("final kind reported without last mark");

    // No new shape is taken while a report is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !m_axis_tvalid || m_axis_tlast)
        else $error("input transfer during a batch report");

    // A stalled summary holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled summary changed");

endmodule

bind shape_area_perimeter_accumulator_unit sapa_checker u_sapa_checker (.*);
